### rtl/core/byte_budget_lru_cache_assert.svh
// Assertion macros for the byte-budget LRU cache.
// Bodies expect clk and rst_n in scope; define NO_ASSERTIONS to drop them.
`ifndef BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BBLRU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BBLRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BBLRU_ASSERT_IMPL(label, ante, cons, msg)
`define BBLRU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/bblru_pkg.sv
// Shared types and constants for the byte-budget LRU cache.
// No dependencies; used by every module of the block except bblru_ram.
package bblru_pkg;

  localparam int BYTE_W   = 30;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int EVICT_W  = 5;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_LOOKUP = 2'd1,
    K_REMOVE = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_ABSENT    = 3'd6,
    ST_DISABLED  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DECIDE,
    S_EVICT_CHK,
    S_EVICT_DROP,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    SW_FIND,
    SW_PROMOTE,
    SW_DEMOTE,
    SW_LRU,
    SW_AGE
  } sweep_mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic [BYTE_W-1:0]  data_size;
    logic [HANDLE_W-1:0] value_handle;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] value_out;
    logic [EVICT_W-1:0]  evicted_count;
    logic [BYTE_W-1:0]   total_bytes;
  } out_word_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic rank_we;
  } slot_act_t;

endpackage

### rtl/core/byte_budget_lru_cache.sv
// Top level of the byte-budget LRU cache: handshakes, budget register, result register.
// Depends on bblru_pkg, bblru_seq and byte_budget_lru_cache_assert.svh.
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall    in_word_t (kind, key, data_size, value_handle)
//   out_     out  out_valid/out_stall  out_word_t (status, value_out, evicted_count, total_bytes)
//   cfg_     in   cfg_wr_en            cfg_wr_data (size_limit)
//
// One request at a time. Each pass sweeps the slots through the single read port of
// the slot RAMs; a request costs one to three passes plus one more per LRU eviction,
// plus the control states of the sequencer.
// rst_n is synchronous; after reset the cache is empty and the budget is zero.
// in_stall is high while a request is in progress; a finished word waits in the
// output register under out_stall while the next request is taken.
module byte_budget_lru_cache import bblru_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int TAG_BITS    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data
);

  `include "byte_budget_lru_cache_assert.svh"

  logic [BYTE_W-1:0] limit_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  logic              seq_idle;
  logic              res_valid;
  logic              res_ack;
  out_word_t         res;
  logic              hit_word;
  logic              quiet_word;
  logic              value_nz;
  logic              evict_nz;

  assign in_stall  = !seq_idle;
  assign res_ack   = res_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  bblru_seq #(
    .ENTRIES     (ENTRIES),
    .TAG_BITS    (TAG_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && seq_idle),
    .req       (in_word),
    .limit     (limit_r),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_word_r <= res;
    end
  end

  assign hit_word   = (out_word_r.status == ST_HIT);
  assign quiet_word = hit_word || (out_word_r.status == ST_MISS) ||
                      (out_word_r.status == ST_UPDATED) || (out_word_r.status == ST_ABSENT) ||
                      (out_word_r.status == ST_DISABLED);
  assign value_nz   = |out_word_r.value_out;
  assign evict_nz   = |out_word_r.evicted_count;

  `BBLRU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy not raised")
  `BBLRU_ASSERT_NEXT(a_result_held, res_valid && !res_ack, res_valid, "pending result dropped")
  `BBLRU_ASSERT_IMPL(a_value_only_on_hit, out_valid_r && value_nz, hit_word, "value without hit")
  `BBLRU_ASSERT_IMPL(a_no_evict_count, out_valid_r && quiet_word, !evict_nz, "stray evict count")

endmodule

### rtl/core/bblru_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bblru_slot_alu.sv
// Per-slot compare and rank-adjust unit, shared by every slot sweep.
// Depends on bblru_pkg.
module bblru_slot_alu import bblru_pkg::*; #(
  parameter int RANK_W   = 4,
  parameter int TAG_BITS = 32
) (
  input  sweep_mode_t         mode,
  input  logic                slot_v,
  input  logic [RANK_W-1:0]   rank,
  input  logic [TAG_BITS-1:0] tag,
  input  logic [TAG_BITS-1:0] key,
  input  logic [RANK_W-1:0]   ref_rank,
  input  logic                sel,
  output slot_act_t           act,
  output logic [RANK_W-1:0]   rank_new
);

  always_comb begin
    act      = '0;
    rank_new = '0;
    case (mode)
      SW_FIND: begin
        act.hit = slot_v && (tag == key);
      end
      SW_LRU: begin
        act.hit = slot_v && (rank == ref_rank);
      end
      SW_PROMOTE: begin
        if (sel) begin
          act.rank_we = 1'b1;
        end else if (slot_v && (rank < ref_rank)) begin
          act.rank_we = 1'b1;
          rank_new    = rank + RANK_W'(1);
        end
      end
      SW_DEMOTE: begin
        if (slot_v && (rank > ref_rank)) begin
          act.rank_we = 1'b1;
          rank_new    = rank - RANK_W'(1);
        end
      end
      SW_AGE: begin
        if (slot_v) begin
          act.rank_we = 1'b1;
          rank_new    = rank + RANK_W'(1);
        end else if (sel) begin
          act.rank_we = 1'b1;
          act.free    = 1'b1;
        end
      end
      default: begin
        act = '0;
      end
    endcase
  end

endmodule

### rtl/core/bblru_seq.sv
// Request sequencer: slot sweeps, eviction loop, byte accounting, valid bits.
// Depends on bblru_pkg, bblru_ram and bblru_slot_alu.
module bblru_seq import bblru_pkg::*; #(
  parameter int ENTRIES     = 16,
  parameter int TAG_BITS    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_word_t          req,
  input  logic [BYTE_W-1:0] limit,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ack,
  output out_word_t         res
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DATA_W = TAG_BITS + BYTE_W + HANDLE_BITS;

  state_t                 state_r, state_nxt;
  sweep_mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pv_r, pv_nxt;
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [BYTE_W-1:0]      bytes_r, bytes_nxt;
  logic                   found_r, found_nxt;

  kind_t                  kind_r, kind_nxt;
  logic [TAG_BITS-1:0]    tag_r, tag_nxt;
  logic [BYTE_W-1:0]      size_r, size_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [IDX_W-1:0]       s_idx_r, s_idx_nxt;
  logic [BYTE_W-1:0]      s_bytes_r, s_bytes_nxt;
  logic [HANDLE_BITS-1:0] s_handle_r, s_handle_nxt;
  logic [IDX_W-1:0]       s_rank_r, s_rank_nxt;
  logic [IDX_W-1:0]       lru_idx_r, lru_idx_nxt;
  logic [BYTE_W-1:0]      lru_bytes_r, lru_bytes_nxt;
  status_t                status_r, status_nxt;
  logic [HANDLE_W-1:0]    value_r, value_nxt;
  logic [EVICT_W-1:0]     evict_r, evict_nxt;

  logic                   issue;
  logic [IDX_W-1:0]       raddr;
  logic                   dwe, rwe;
  logic [DATA_W-1:0]      dwdata, drd;
  logic [IDX_W-1:0]       rwdata, rrd;
  logic [TAG_BITS-1:0]    d_tag;
  logic [BYTE_W-1:0]      d_bytes;
  logic [HANDLE_BITS-1:0] d_handle;
  logic                   is_sel;
  logic [IDX_W-1:0]       ref_rank;
  slot_act_t              act;
  logic [IDX_W-1:0]       rank_new;
  logic [BYTE_W:0]        fit_sum;
  logic                   fit_over;
  logic                   too_large;
  logic [BYTE_W-1:0]      sub_b;
  logic [BYTE_W-1:0]      sat_sub;

  assign issue  = (cnt_r != CNT_W'(ENTRIES));
  assign raddr  = issue ? cnt_r[IDX_W-1:0] : '0;

  assign d_tag    = drd[HANDLE_BITS + BYTE_W +: TAG_BITS];
  assign d_bytes  = drd[HANDLE_BITS +: BYTE_W];
  assign d_handle = drd[HANDLE_BITS-1:0];

  assign is_sel   = (mode_r == SW_AGE) ? !found_r : (pidx_r == s_idx_r);
  assign ref_rank = (mode_r == SW_LRU) ? IDX_W'(n_r - CNT_W'(1)) : s_rank_r;

  assign fit_sum   = {1'b0, size_r} + {1'b0, bytes_r};
  assign fit_over  = fit_sum > {1'b0, limit};
  assign too_large = size_r > (limit >> 1);
  // shared saturating subtract for every slot drop
  assign sub_b     = (state_r == S_EVICT_DROP) ? lru_bytes_r : s_bytes_r;
  assign sat_sub   = (bytes_r >= sub_b) ? (bytes_r - sub_b) : '0;

  bblru_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (pidx_r),
    .wdata (dwdata),
    .raddr (raddr),
    .rdata (drd)
  );

  bblru_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (pidx_r),
    .wdata (rwdata),
    .raddr (raddr),
    .rdata (rrd)
  );

  bblru_slot_alu #(
    .RANK_W   (IDX_W),
    .TAG_BITS (TAG_BITS)
  ) u_alu (
    .mode     (mode_r),
    .slot_v   (valid_r[pidx_r]),
    .rank     (rrd),
    .tag      (d_tag),
    .key      (tag_r),
    .ref_rank (ref_rank),
    .sel      (is_sel),
    .act      (act),
    .rank_new (rank_new)
  );

  assign res = '{status: status_r, value_out: value_r, evicted_count: evict_r,
                 total_bytes: bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= SW_FIND;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      valid_r <= '0;
      n_r     <= '0;
      bytes_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      valid_r <= valid_nxt;
      n_r     <= n_nxt;
      bytes_r <= bytes_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    kind_r      <= kind_nxt;
    tag_r       <= tag_nxt;
    size_r      <= size_nxt;
    handle_r    <= handle_nxt;
    s_idx_r     <= s_idx_nxt;
    s_bytes_r   <= s_bytes_nxt;
    s_handle_r  <= s_handle_nxt;
    s_rank_r    <= s_rank_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_bytes_r <= lru_bytes_nxt;
    status_r    <= status_nxt;
    value_r     <= value_nxt;
    evict_r     <= evict_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    valid_nxt     = valid_r;
    n_nxt         = n_r;
    bytes_nxt     = bytes_r;
    found_nxt     = found_r;
    kind_nxt      = kind_r;
    tag_nxt       = tag_r;
    size_nxt      = size_r;
    handle_nxt    = handle_r;
    s_idx_nxt     = s_idx_r;
    s_bytes_nxt   = s_bytes_r;
    s_handle_nxt  = s_handle_r;
    s_rank_nxt    = s_rank_r;
    lru_idx_nxt   = lru_idx_r;
    lru_bytes_nxt = lru_bytes_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    evict_nxt     = evict_r;
    dwe           = 1'b0;
    dwdata        = {tag_r, size_r, handle_r};
    rwe           = 1'b0;
    rwdata        = rank_new;
    idle          = 1'b0;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          kind_nxt   = req.kind;
          tag_nxt    = TAG_BITS'(req.key);
          size_nxt   = req.data_size;
          handle_nxt = HANDLE_BITS'(req.value_handle);
          found_nxt  = 1'b0;
          evict_nxt  = '0;
          value_nxt  = '0;
          state_nxt  = S_SWEEP;
          mode_nxt   = SW_FIND;
          cnt_nxt    = '0;
          pv_nxt     = 1'b0;
        end
      end

      S_SWEEP: begin
        if (issue) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          rwe = act.rank_we;
          case (mode_r)
            SW_FIND: begin
              if (act.hit && !found_r) begin
                found_nxt    = 1'b1;
                s_idx_nxt    = pidx_r;
                s_bytes_nxt  = d_bytes;
                s_handle_nxt = d_handle;
                s_rank_nxt   = rrd;
              end
            end
            SW_LRU: begin
              if (act.hit) begin
                lru_idx_nxt   = pidx_r;
                lru_bytes_nxt = d_bytes;
              end
            end
            SW_PROMOTE: begin
              // in-place update rewrites size and handle
              dwe = is_sel && (kind_r == K_INSERT);
            end
            SW_DEMOTE: begin
              rwe = act.rank_we;
            end
            SW_AGE: begin
              if (act.free) begin
                dwe               = 1'b1;
                valid_nxt[pidx_r] = 1'b1;
                found_nxt         = 1'b1;
              end
            end
            default: begin
              rwe = 1'b0;
            end
          endcase
        end
        if (!issue && !pv_r) begin
          case (mode_r)
            SW_FIND:    state_nxt = S_DECIDE;
            SW_PROMOTE: state_nxt = S_FINISH;
            SW_DEMOTE: begin
              if (kind_r == K_INSERT && status_r == ST_INSERTED) begin
                state_nxt = S_EVICT_CHK;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            SW_LRU:     state_nxt = S_EVICT_DROP;
            SW_AGE: begin
              bytes_nxt = bytes_r + size_r;
              n_nxt     = n_r + CNT_W'(1);
              state_nxt = S_FINISH;
            end
            default:    state_nxt = S_FINISH;
          endcase
        end
      end

      S_DECIDE: begin
        state_nxt = S_FINISH;
        case (kind_r)
          K_CLEAR: begin
            valid_nxt  = '0;
            bytes_nxt  = '0;
            n_nxt      = '0;
            evict_nxt  = EVICT_W'(n_r);
            status_nxt = ST_REMOVED;
          end
          K_LOOKUP: begin
            if (found_r) begin
              value_nxt  = HANDLE_W'(s_handle_r);
              status_nxt = ST_HIT;
              state_nxt  = S_SWEEP;
              mode_nxt   = SW_PROMOTE;
              cnt_nxt    = '0;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          K_REMOVE: begin
            if (found_r) begin
              valid_nxt[s_idx_r] = 1'b0;
              bytes_nxt          = sat_sub;
              n_nxt              = n_r - CNT_W'(1);
              evict_nxt          = EVICT_W'(1);
              status_nxt         = ST_REMOVED;
              state_nxt          = S_SWEEP;
              mode_nxt           = SW_DEMOTE;
              cnt_nxt            = '0;
            end else begin
              status_nxt = ST_ABSENT;
            end
          end
          K_INSERT: begin
            if (limit == '0) begin
              status_nxt = ST_DISABLED;
            end else if (!too_large && found_r && s_bytes_r >= size_r) begin
              bytes_nxt  = bytes_r - s_bytes_r + size_r;
              status_nxt = ST_UPDATED;
              state_nxt  = S_SWEEP;
              mode_nxt   = SW_PROMOTE;
              cnt_nxt    = '0;
            end else begin
              status_nxt = too_large ? ST_TOO_LARGE : ST_INSERTED;
              if (found_r) begin
                valid_nxt[s_idx_r] = 1'b0;
                bytes_nxt          = sat_sub;
                n_nxt              = n_r - CNT_W'(1);
                evict_nxt          = EVICT_W'(1);
                state_nxt          = S_SWEEP;
                mode_nxt           = SW_DEMOTE;
                cnt_nxt            = '0;
              end else if (!too_large) begin
                state_nxt = S_EVICT_CHK;
              end
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_EVICT_CHK: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
        if (n_r != '0 && (fit_over || n_r == CNT_W'(ENTRIES))) begin
          mode_nxt = SW_LRU;
        end else begin
          if (n_r == '0) begin
            bytes_nxt = '0;
          end
          found_nxt = 1'b0;
          mode_nxt  = SW_AGE;
        end
      end

      S_EVICT_DROP: begin
        valid_nxt[lru_idx_r] = 1'b0;
        bytes_nxt            = sat_sub;
        n_nxt                = n_r - CNT_W'(1);
        evict_nxt            = evict_r + EVICT_W'(1);
        state_nxt            = S_EVICT_CHK;
      end

      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### dv/tb_top.sv
// Self-checking testbench for byte_budget_lru_cache: random and directed cache requests.
// Predicts every result word in-line and compares it field by field.
// Depends on bblru_pkg and the RTL of byte_budget_lru_cache.
`timescale 1ns / 1ps

module tb_top;
  import bblru_pkg::*;

  localparam int NSLOT = 16;
  localparam int KEYS = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [BYTE_W-1:0] BUDGET_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [BYTE_W-1:0] cfg_wr_data = '0;

  in_word_t req_backlog[$];
  out_word_t due_replies[$];
  logic [KEY_W-1:0] key_pool[KEYS];

  int send_idle_pct = 28;
  int recv_idle_pct = 28;
  int hold_req = 0;
  int hold_left = 0;
  int mismatches = 0;
  int unsigned cycle_count = 0;

  // predicted cache contents
  logic slot_live[NSLOT];
  logic [KEY_W-1:0] slot_key[NSLOT];
  logic [BYTE_W-1:0] slot_size[NSLOT];
  logic [HANDLE_W-1:0] slot_hdl[NSLOT];
  int slot_age[NSLOT];
  logic [BYTE_W-1:0] bytes_used;
  logic [BYTE_W-1:0] budget_bytes;

  byte_budget_lru_cache #(
    .ENTRIES(NSLOT),
    .TAG_BITS(KEY_W),
    .HANDLE_BITS(HANDLE_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  function automatic int slot_of(logic [KEY_W-1:0] k);
    for (int i = 0; i < NSLOT; i++) if (slot_live[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void touch_slot(int s);
    int rank;
    rank = slot_age[s];
    for (int i = 0; i < NSLOT; i++) if (slot_live[i] && slot_age[i] < rank) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void evict_slot(int s);
    int rank;
    rank = slot_age[s];
    slot_live[s] = 1'b0;
    for (int i = 0; i < NSLOT; i++) if (slot_live[i] && slot_age[i] > rank) slot_age[i]--;
    bytes_used = (bytes_used >= slot_size[s]) ? bytes_used - slot_size[s] : '0;
  endfunction

  function automatic out_word_t resolve_request(in_word_t w);
    out_word_t r;
    int s;
    int victim;
    int dropped;
    r = '0;
    dropped = 0;
    s = slot_of(w.key);
    case (w.kind)
      K_INSERT: begin
        if (budget_bytes == 0) begin
          r.status = ST_DISABLED;
        end else if (w.data_size > (budget_bytes >> 1)) begin
          if (s >= 0) begin
            evict_slot(s);
            dropped++;
          end
          r.status = ST_TOO_LARGE;
        end else if (s >= 0 && slot_size[s] >= w.data_size) begin
          bytes_used = bytes_used - slot_size[s] + w.data_size;
          slot_size[s] = w.data_size;
          slot_hdl[s] = w.value_handle;
          touch_slot(s);
          r.status = ST_UPDATED;
        end else begin
          if (s >= 0) begin
            evict_slot(s);
            dropped++;
          end
          while (live_slots() > 0 && ({2'b0, w.data_size} + {2'b0, bytes_used} >
                 {2'b0, budget_bytes} || live_slots() >= NSLOT)) begin
            victim = -1;
            for (int i = 0; i < NSLOT; i++)
              if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
            evict_slot(victim);
            dropped++;
          end
          if (live_slots() == 0) bytes_used = '0;
          victim = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_live[i]) slot_age[i]++;
            else if (victim < 0) victim = i;
          end
          if (victim >= 0) begin
            slot_live[victim] = 1'b1;
            slot_key[victim] = w.key;
            slot_size[victim] = w.data_size;
            slot_hdl[victim] = w.value_handle;
            slot_age[victim] = 0;
            bytes_used = bytes_used + w.data_size;
          end
          r.status = ST_INSERTED;
        end
      end
      K_LOOKUP: begin
        if (s >= 0) begin
          touch_slot(s);
          r.value_out = slot_hdl[s];
          r.status = ST_HIT;
        end else begin
          r.status = ST_MISS;
        end
      end
      K_REMOVE: begin
        if (s >= 0) begin
          evict_slot(s);
          dropped = 1;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_live[i]) dropped++;
          slot_live[i] = 1'b0;
        end
        bytes_used = '0;
        r.status = ST_REMOVED;
      end
    endcase
    r.evicted_count = dropped[EVICT_W-1:0];
    r.total_bytes = bytes_used;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        due_replies.insert(due_replies.size(), resolve_request(in_word));
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_word);
        end else begin
          want = due_replies.pop_front();
          if (out_word.status !== want.status || out_word.value_out !== want.value_out ||
              out_word.evicted_count !== want.evicted_count ||
              out_word.total_bytes !== want.total_bytes) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp status %0d value %h evicted %0d total %0d",
                       want.status, want.value_out, want.evicted_count, want.total_bytes);
              $display("          got status %0d value %h evicted %0d total %0d",
                       out_word.status, out_word.value_out, out_word.evicted_count,
                       out_word.total_bytes);
            end
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_req(input kind_t kd, input logic [KEY_W-1:0] k,
                           input logic [BYTE_W-1:0] sz, input logic [HANDLE_W-1:0] h);
    in_word_t w;
    w.kind = kd;
    w.key = k;
    w.data_size = sz;
    w.value_handle = h;
    req_backlog.insert(req_backlog.size(), w);
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || in_valid || due_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_budget(input logic [BYTE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    budget_bytes = v;
    @(negedge clk);
  endtask

  task automatic run_random(input int n, input int idle_pct, input int hold);
    int pick;
    kind_t kd;
    logic [KEY_W-1:0] k;
    logic [BYTE_W-1:0] sz;
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      if (pick < 46) kd = K_INSERT;
      else if (pick < 76) kd = K_LOOKUP;
      else if (pick < 97) kd = K_REMOVE;
      else kd = K_CLEAR;
      k = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(KEYS - 1)];
      pick = $urandom_range(99);
      if (pick < 6) sz = BYTE_W'($urandom);
      else if (pick < 14) sz = (budget_bytes >> 1) + BYTE_W'($urandom_range(1));
      else if (pick < 60) sz = BYTE_W'($urandom_range(int'(budget_bytes / 20)));
      else sz = BYTE_W'($urandom_range(int'(budget_bytes / 3)));
      queue_req(kd, k, sz, HANDLE_W'($urandom));
    end
    if (hold > 0) begin
      repeat (50) @(negedge clk);
      hold_req = hold;
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i] = '0;
      slot_size[i] = '0;
      slot_hdl[i] = '0;
      slot_age[i] = 0;
    end
    bytes_used = '0;
    budget_bytes = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEYS; i++) key_pool[i] = KEY_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // budget still zero out of reset
    queue_req(K_INSERT, 32'h0000_0010, 30'd5, 32'h1234_5678);
    queue_req(K_LOOKUP, 32'h0000_0010, '0, '0);
    queue_req(K_REMOVE, 32'h0000_0010, '0, '0);
    queue_req(K_CLEAR, '0, '0, '0);
    drain();

    set_budget(30'd1000);
    queue_req(K_INSERT, '0, 30'd0, '1);
    queue_req(K_INSERT, '1, 30'd500, '0);
    queue_req(K_LOOKUP, '0, '1, '1);
    queue_req(K_INSERT, '0, 30'd0, 32'h0000_0001);
    queue_req(K_INSERT, '1, 30'd501, 32'h5555_5555);
    queue_req(K_INSERT, 32'd7, 30'd300, 32'hAAAA_AAAA);
    queue_req(K_INSERT, 32'd7, 30'd450, 32'h0F0F_0F0F);
    queue_req(K_INSERT, 32'd8, 30'd500, 32'hF0F0_F0F0);
    queue_req(K_INSERT, 32'd9, 30'd400, 32'h1357_9BDF);
    queue_req(K_REMOVE, 32'd8, '0, '0);
    queue_req(K_REMOVE, 32'd8, '0, '0);
    queue_req(K_INSERT, '1, '1, '1);
    queue_req(K_CLEAR, '0, '0, '0);
    queue_req(K_LOOKUP, 32'd9, '0, '0);
    drain();

    set_budget(BUDGET_MAX);
    run_random(200, 28, 700);
    set_budget(30'd5000);
    run_random(200, 0, 0);
    set_budget(30'd200);
    run_random(120, 28, 0);
    set_budget(30'd1);
    run_random(60, 28, 0);
    set_budget(30'd0);
    run_random(40, 28, 0);
    set_budget(BYTE_W'($urandom_range(100000, 4000)));
    run_random(130, 28, 0);
    set_budget(BUDGET_MAX);
    run_random(100, 28, 0);

    repeat (400) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
